>>> design/ipid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ipid_pkg;

	// width of the external word fields
	localparam int OUT_W = 32;

	// configuration register map
	localparam int IDX_W = 2;
	typedef enum logic [IDX_W-1:0] {
		REG_KP = 2'd0,
		REG_KI = 2'd1,
		REG_KD = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	// item mode codes
	localparam logic MODE_RUN   = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// decoupling queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// queue status seen by the back end and the credit logic
	typedef struct packed {
		logic              head_valid;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage
`default_nettype wire

>>> design/ipid_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ipid_front #(
	parameter int DW = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [ipid_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [ipid_pkg::OUT_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      mode,
	input  wire logic [ipid_pkg::OUT_W-1:0] error_sample,
	input  wire ipid_pkg::q_status_t       q_stat,
	output logic                           push,
	output logic [DW:0]                    push_data
);
	import ipid_pkg::*;

	logic [DW-1:0] kp_q, ki_q, kd_q;
	logic [DW-1:0] a0_q, a1_q, a2_q;
	logic [DW-1:0] nkp, nki, nkd;
	logic          idx_ok;
	logic [DW-1:0] x1_q, x2_q;
	logic [DW-1:0] x_in;
	logic          accept;
	logic [QCNT_W-1:0] occ;
	logic          valid_s1, clr_s1;
	logic [DW-1:0] p0_s1, p1_s1, p2_s1;

	// new gain set as it stands after this write
	always_comb begin
		nkp = kp_q;
		nki = ki_q;
		nkd = kd_q;
		idx_ok = 1'b1;
		case (reg_idx_t'(cfg_index))
			REG_KP: nkp = cfg_data[DW-1:0];
			REG_KI: nki = cfg_data[DW-1:0];
			REG_KD: nkd = cfg_data[DW-1:0];
			default: idx_ok = 1'b0;
		endcase
	end

	// coefficients refreshed with the write, ready for the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			a0_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wen && idx_ok) begin
			kp_q <= nkp;
			ki_q <= nki;
			kd_q <= nkd;
			a0_q <= nkp + nki + nkd;
			a1_q <= DW'(0) - nkp - {nkd[DW-2:0], 1'b0};
			a2_q <= nkd;
		end
	end

	// room in the queue for everything in flight
	assign occ      = q_stat.count + QCNT_W'(valid_s1);
	assign in_stall = (occ >= QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign x_in     = error_sample[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q     <= '0;
			x2_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (mode == MODE_CLEAR) begin
					x1_q <= '0;
					x2_q <= '0;
				end else begin
					x1_q <= x_in;
					x2_q <= x1_q;
				end
			end
		end
	end

	// products, low bits only
	always_ff @(posedge clk) begin
		if (accept) begin
			clr_s1 <= (mode == MODE_CLEAR);
			p0_s1  <= DW'(a0_q * x_in);
			p1_s1  <= DW'(a1_q * x1_q);
			p2_s1  <= DW'(a2_q * x2_q);
		end
	end

	assign push      = valid_s1;
	assign push_data = {clr_s1, p0_s1 + p1_s1 + p2_s1};

endmodule
`default_nettype wire

>>> design/ipid_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ipid_queue #(
	parameter int W = 33
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic [W-1:0]    din,
	input  wire logic            pop,
	output logic [W-1:0]         dout,
	output ipid_pkg::q_status_t  stat
);
	import ipid_pkg::*;

	logic [W-1:0]      mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	assign dout            = mem_q[rd_q];
	assign stat.count      = cnt_q;
	assign stat.head_valid = (cnt_q != '0);

endmodule
`default_nettype wire

>>> design/ipid_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ipid_back #(
	parameter int DW = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ipid_pkg::q_status_t        q_stat,
	input  wire logic [DW:0]                q_dout,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [ipid_pkg::OUT_W-1:0]      drive_value
);
	import ipid_pkg::*;

	logic [DW-1:0] last_drive_q, drive_q;
	logic          out_valid_q;
	logic [DW-1:0] y;

	assign pop = q_stat.head_valid && (!out_valid_q || !out_stall);
	assign y   = q_dout[DW] ? '0 : last_drive_q + q_dout[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drive_q <= '0;
			out_valid_q  <= 1'b0;
		end else if (pop) begin
			last_drive_q <= y;
			out_valid_q  <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			drive_q <= y;
	end

	assign out_valid   = out_valid_q;
	assign drive_value = OUT_W'(signed'(drive_q));

endmodule
`default_nettype wire

>>> design/incremental_pid_integer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   valid      stall      payload
// config    cfg_wen    -          cfg_index, cfg_data
// input     in_valid   in_stall   mode, error_sample
// output    out_valid  out_stall  drive_value
//
// one word per cycle sustained while out_stall is low; a word reaches drive_value through the
// product register (loaded at its accepting edge), then the queue, then the output register,
// with a single multiply stage
// reset clears gains, coefficients, error history, last output and all valid state
// the front stalls once the queued words plus the word in its product stage reach four
// an output stall backs up the queue; the front keeps accepting until it fills
module incremental_pid_integer #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [ipid_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [ipid_pkg::OUT_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       mode,
	input  wire logic [ipid_pkg::OUT_W-1:0] error_sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [ipid_pkg::OUT_W-1:0]      drive_value
);
	import ipid_pkg::*;

	// queue word: clear flag above the summed products
	logic              q_push, q_pop;
	logic [DATA_WIDTH:0] q_din, q_dout;
	q_status_t         q_stat;

	// front: gains, coefficients, error history and the three products
	ipid_front #(.DW(DATA_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.error_sample (error_sample),
		.q_stat       (q_stat),
		.push         (q_push),
		.push_data    (q_din)
	);

	// short queue so output stalls do not reach the multipliers at once
	ipid_queue #(.W(DATA_WIDTH + 1)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.stat   (q_stat)
	);

	// back: running output accumulation and the output register
	ipid_back #(.DW(DATA_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_dout      (q_dout),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_value (drive_value)
	);

	// credit scheme must never overfill the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_stat.count < QCNT_W'(QDEPTH) || q_pop))
		else $error("queue push while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	// a clear word leaves a zero result
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_dout[DATA_WIDTH]) |=> (out_valid && drive_value == '0))
		else $error("clear did not give zero");

endmodule
`default_nettype wire
